// ----- hdl/key_value_table_defines.svh -----
// Assertion macros for the key-value table.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

// Overlapping implication, sampled at the rising edge, off while reset is held.
`define KVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the following cycle, off while reset is held.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/kvt_pkg.sv -----
// Shared types and constants of the key-value table.
// Depends on nothing; used by the interfaces, kvt_dp, kvt_ctrl, the top level and the bench.
package kvt_pkg;

	localparam int CAPACITY    = 256;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int KIND_W   = 3;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 8;
	localparam int COUNT_W  = 9;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT      = 3'd0,
		KIND_UPDATE      = 3'd1,
		KIND_INS_UPD     = 3'd2,
		KIND_ERASE       = 3'd3,
		KIND_LOOKUP      = 3'd4,
		KIND_READ_INDEX  = 3'd5
	} kind_t;

	// Read address source of both stores.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_SCAN,
		RD_LAST,
		RD_INDEX
	} rd_sel_t;

	// Write action on the stores and the entry count.
	typedef enum logic [1:0] {
		WR_NONE,
		WR_VALUE_HIT,
		WR_APPEND,
		WR_MOVE_LAST
	} wr_sel_t;

	typedef struct packed {
		logic    load_cmd;
		rd_sel_t rd;
		wr_sel_t wr;
		logic    set_ok;
		logic    cap_pos;
		logic    cap_key;
		logic    cap_value;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              count_zero;
		logic              count_full;
		logic              match;
		logic              scan_miss;
		logic              index_ok;
	} status_t;

endpackage

// ----- hdl/kvt_req_if.sv -----
// Request channel of the key-value table: valid, ready and one operation.
// Depends on kvt_pkg for the field widths.
interface kvt_req_if;
	logic                         valid;
	logic                         ready;
	logic [kvt_pkg::KIND_W-1:0]   kind;
	logic [kvt_pkg::KEY_W-1:0]    key;
	logic [kvt_pkg::VALUE_W-1:0]  value;
	logic [kvt_pkg::INDEX_W-1:0]  index;

	modport source (output valid, kind, key, value, index, input ready);
	modport sink (input valid, kind, key, value, index, output ready);
endinterface

// ----- hdl/kvt_rsp_if.sv -----
// Response channel of the key-value table: valid, ready and one result.
// Depends on kvt_pkg for the field widths.
interface kvt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [kvt_pkg::KEY_W-1:0]    key_out;
	logic [kvt_pkg::VALUE_W-1:0]  value_out;
	logic [kvt_pkg::COUNT_W-1:0]  entry_count;
	logic                         is_empty;

	modport source (output valid, ok, key_out, value_out, entry_count, is_empty, input ready);
	modport sink (input valid, ok, key_out, value_out, entry_count, is_empty, output ready);
endinterface

// ----- hdl/kvt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hdl/kvt_dp.sv -----
// Datapath of the key-value table: operand registers, entry count, key and
// value stores, scan compare and the result register. Depends on kvt_pkg, kvt_ram.
module kvt_dp #(
	parameter int CAPACITY    = kvt_pkg::CAPACITY,
	parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH,
	parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kvt_pkg::cmd_t                 cmd,
	output kvt_pkg::status_t              status,
	input  logic [kvt_pkg::KIND_W-1:0]    in_kind,
	input  logic [kvt_pkg::KEY_W-1:0]     in_key,
	input  logic [kvt_pkg::VALUE_W-1:0]   in_value,
	input  logic [kvt_pkg::INDEX_W-1:0]   in_index,
	output logic                          out_ok,
	output logic [kvt_pkg::KEY_W-1:0]     out_key,
	output logic [kvt_pkg::VALUE_W-1:0]   out_value,
	output logic [kvt_pkg::COUNT_W-1:0]   out_count,
	output logic                          out_empty
);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > kvt_pkg::INDEX_W) ? CNT_W : kvt_pkg::INDEX_W;

	logic [kvt_pkg::KIND_W-1:0]  kind_q;
	logic [KEY_WIDTH-1:0]        key_q;
	logic [VALUE_WIDTH-1:0]      value_q;
	logic [kvt_pkg::INDEX_W-1:0] index_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            scan_q;
	logic                        rd_valid_s1;
	logic [ADDR_W-1:0]           rd_addr_s1;
	logic [ADDR_W-1:0]           pos_q;
	logic                        res_ok_q;
	logic [KEY_WIDTH-1:0]        res_key_q;
	logic [VALUE_WIDTH-1:0]      res_value_q;
	logic                        out_ok_q;
	logic [kvt_pkg::KEY_W-1:0]   out_key_q;
	logic [kvt_pkg::VALUE_W-1:0] out_value_q;
	logic [kvt_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_empty_q;

	logic [CNT_W-1:0]       last_idx;
	logic                   re;
	logic [ADDR_W-1:0]      raddr;
	logic                   key_we;
	logic                   value_we;
	logic [ADDR_W-1:0]      waddr;
	logic [KEY_WIDTH-1:0]   key_wdata;
	logic [VALUE_WIDTH-1:0] value_wdata;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [VALUE_WIDTH-1:0] value_rdata;

	assign last_idx = count_q - CNT_W'(1);

	always_comb begin
		re    = (cmd.rd != kvt_pkg::RD_NONE);
		raddr = '0;
		case (cmd.rd)
			kvt_pkg::RD_SCAN:  raddr = ADDR_W'(scan_q);
			kvt_pkg::RD_LAST:  raddr = ADDR_W'(last_idx);
			kvt_pkg::RD_INDEX: raddr = ADDR_W'(index_q);
			default:           raddr = '0;
		endcase
	end

	always_comb begin
		key_we      = 1'b0;
		value_we    = 1'b0;
		waddr       = '0;
		key_wdata   = key_q;
		value_wdata = value_q;
		case (cmd.wr)
			kvt_pkg::WR_VALUE_HIT: begin
				value_we = 1'b1;
				waddr    = rd_addr_s1;
			end
			kvt_pkg::WR_APPEND: begin
				key_we   = 1'b1;
				value_we = 1'b1;
				waddr    = ADDR_W'(count_q);
			end
			kvt_pkg::WR_MOVE_LAST: begin
				// The last entry fills the hole left by the erased one.
				key_we      = 1'b1;
				value_we    = 1'b1;
				waddr       = pos_q;
				key_wdata   = key_rdata;
				value_wdata = value_rdata;
			end
			default: begin
				key_we = 1'b0;
			end
		endcase
	end

	kvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (key_rdata)
	);

	kvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
		.clk   (clk),
		.we    (value_we),
		.waddr (waddr),
		.wdata (value_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (value_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.load_cmd) begin
				scan_q <= '0;
			end else if (cmd.rd == kvt_pkg::RD_SCAN) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			rd_valid_s1 <= (cmd.rd == kvt_pkg::RD_SCAN) && (scan_q < count_q);
			if (cmd.wr == kvt_pkg::WR_APPEND) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.wr == kvt_pkg::WR_MOVE_LAST) begin
				count_q <= last_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= ADDR_W'(scan_q);
		if (cmd.load_cmd) begin
			kind_q      <= in_kind;
			key_q       <= KEY_WIDTH'(in_key);
			value_q     <= VALUE_WIDTH'(in_value);
			index_q     <= in_index;
			res_ok_q    <= 1'b0;
			res_key_q   <= '0;
			res_value_q <= '0;
		end else begin
			if (cmd.set_ok) begin
				res_ok_q <= 1'b1;
			end
			if (cmd.cap_key) begin
				res_key_q <= key_rdata;
			end
			if (cmd.cap_value) begin
				res_value_q <= value_rdata;
			end
		end
		if (cmd.cap_pos) begin
			pos_q <= rd_addr_s1;
		end
		if (cmd.load_out) begin
			out_ok_q    <= res_ok_q;
			out_key_q   <= kvt_pkg::KEY_W'(res_key_q);
			out_value_q <= kvt_pkg::VALUE_W'(res_value_q);
			out_count_q <= kvt_pkg::COUNT_W'(count_q);
			out_empty_q <= (count_q == '0);
		end
	end

	always_comb begin
		status.kind       = kind_q;
		status.count_zero = (count_q == '0);
		status.count_full = (count_q == CNT_W'(CAPACITY));
		status.match      = rd_valid_s1 && (key_rdata == key_q);
		status.scan_miss  = rd_valid_s1 && (key_rdata != key_q)
			&& (CNT_W'(rd_addr_s1) == last_idx);
		status.index_ok   = (CMP_W'(index_q) < CMP_W'(count_q));
	end

	assign out_ok    = out_ok_q;
	assign out_key   = out_key_q;
	assign out_value = out_value_q;
	assign out_count = out_count_q;
	assign out_empty = out_empty_q;
endmodule

// ----- hdl/kvt_ctrl.sv -----
// Controller of the key-value table: sequences accept, scan, store update
// and result hand-off. Depends on kvt_pkg.
module kvt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  kvt_pkg::status_t  status,
	output kvt_pkg::cmd_t     cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_ERASE_RD,
		S_ERASE_WR,
		S_IDX_CAP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   appendable;

	// An absent key may be appended by insert and insert-or-update if there is room.
	assign appendable = ((status.kind == kvt_pkg::KIND_INSERT)
		|| (status.kind == kvt_pkg::KIND_INS_UPD)) && !status.count_full;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_cmd = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (status.kind)
					kvt_pkg::KIND_INSERT, kvt_pkg::KIND_UPDATE, kvt_pkg::KIND_INS_UPD,
					kvt_pkg::KIND_ERASE, kvt_pkg::KIND_LOOKUP: begin
						if (status.count_zero) begin
							if (appendable) begin
								cmd.wr     = kvt_pkg::WR_APPEND;
								cmd.set_ok = 1'b1;
							end
							state_d = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end
					kvt_pkg::KIND_READ_INDEX: begin
						if (status.index_ok) begin
							cmd.rd  = kvt_pkg::RD_INDEX;
							state_d = S_IDX_CAP;
						end else begin
							state_d = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.rd = kvt_pkg::RD_SCAN;
				if (status.match) begin
					case (status.kind)
						kvt_pkg::KIND_UPDATE, kvt_pkg::KIND_INS_UPD: begin
							cmd.wr     = kvt_pkg::WR_VALUE_HIT;
							cmd.set_ok = 1'b1;
							state_d    = S_DONE;
						end
						kvt_pkg::KIND_ERASE: begin
							cmd.cap_pos = 1'b1;
							cmd.set_ok  = 1'b1;
							state_d     = S_ERASE_RD;
						end
						kvt_pkg::KIND_LOOKUP: begin
							cmd.cap_value = 1'b1;
							cmd.set_ok    = 1'b1;
							state_d       = S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end else if (status.scan_miss) begin
					if (appendable) begin
						cmd.wr     = kvt_pkg::WR_APPEND;
						cmd.set_ok = 1'b1;
					end
					state_d = S_DONE;
				end
			end
			S_ERASE_RD: begin
				cmd.rd  = kvt_pkg::RD_LAST;
				state_d = S_ERASE_WR;
			end
			S_ERASE_WR: begin
				cmd.wr  = kvt_pkg::WR_MOVE_LAST;
				state_d = S_DONE;
			end
			S_IDX_CAP: begin
				cmd.cap_key   = 1'b1;
				cmd.cap_value = 1'b1;
				cmd.set_ok    = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule

// ----- hdl/key_value_table.sv -----
// Top level of the key-value table: controller, datapath and assertions.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_ctrl, kvt_dp and the defines header.
//
// Usage. Each beat on the req channel is one operation (insert, update,
// insert-or-update, erase, lookup by key or read by index) and gives exactly
// one beat on the rsp channel, carrying the success flag, the key and value
// read, the entry count after the operation and an empty flag.
// Operations are handled one at a time. A read by index below the count reads
// both stores and captures the key and value; an index past the count, an
// undefined kind or any kind on an empty table is settled at dispatch; a key
// is searched from the first position until a match or the last entry, and
// erase then reads the last entry and moves it into the hole. The search is
// one read of the key store per cycle. A new request is taken in the cycle
// after the result has been placed in the output register, even while that
// result still waits.
// Reset clears the entry count, so the table is empty; the stores need no
// clearing. If the receiver stalls, the result waits in the output register
// and a finished operation holds in its last state until the register frees.
`include "key_value_table_defines.svh"

module key_value_table #(
	parameter int CAPACITY    = kvt_pkg::CAPACITY,
	parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH,
	parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);
	// Command and status between the controller and the datapath.
	kvt_pkg::cmd_t    ctrl_cmd;
	kvt_pkg::status_t dp_status;

	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (dp_status),
		.cmd       (ctrl_cmd)
	);

	kvt_dp #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctrl_cmd),
		.status    (dp_status),
		.in_kind   (req.kind),
		.in_key    (req.key),
		.in_value  (req.value),
		.in_index  (req.index),
		.out_ok    (rsp.ok),
		.out_key   (rsp.key_out),
		.out_value (rsp.value_out),
		.out_count (rsp.entry_count),
		.out_empty (rsp.is_empty)
	);

	// Only one operation is in work: an accepted beat closes the request side.
	`KVT_ASSERT_NEXT(a_one_in_work, clk, arst_n, req.valid && req.ready, !req.ready, "request taken while an operation is in work")
	// A failed operation reports no key and no value.
	`KVT_ASSERT_IMP(a_fail_zero, clk, arst_n, rsp.valid && !rsp.ok, (rsp.key_out == '0) && (rsp.value_out == '0), "failed result carries data")
	// The controller never appends to a full table.
	`KVT_ASSERT_IMP(a_no_overfill, clk, arst_n, ctrl_cmd.wr == kvt_pkg::WR_APPEND, !dp_status.count_full, "append to a full table")
endmodule

// ----- sim/key_value_table_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard of the key-value table: keeps a mirror of the table from request beats
// and checks every response beat. Depends on kvt_pkg, kvt_req_if and kvt_rsp_if.
module key_value_table_checker (
	input  logic clk,
	input  logic arst_n,
	kvt_req_if   req,
	kvt_rsp_if   rsp,
	output int   fail_count,
	output int   outstanding
);
	import kvt_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [KEY_W-1:0]   key_out;
		logic [VALUE_W-1:0] value_out;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
	} table_result_t;

	table_result_t      awaited_results[$];
	logic [KEY_W-1:0]   key_mirror   [CAPACITY];
	logic [VALUE_W-1:0] value_mirror [CAPACITY];
	int                 mirror_count;
	int unsigned        beat_number;

	// Entries are searched in ascending position, as the block does.
	function automatic int find_key_position(logic [KEY_W-1:0] key);
		for (int p = 0; p < mirror_count; p++) begin
			if (key_mirror[p] == key)
				return p;
		end
		return -1;
	endfunction

	function automatic table_result_t apply_operation(logic [KIND_W-1:0] kind,
			logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] index);
		table_result_t outcome;
		int            pos;
		outcome.ok        = 1'b0;
		outcome.key_out   = '0;
		outcome.value_out = '0;
		pos = find_key_position(key);
		case (kind)
			KIND_INSERT: begin
				if (pos < 0 && mirror_count < CAPACITY) begin
					key_mirror[mirror_count]   = key;
					value_mirror[mirror_count] = value;
					mirror_count++;
					outcome.ok = 1'b1;
				end
			end
			KIND_UPDATE: begin
				if (pos >= 0) begin
					value_mirror[pos] = value;
					outcome.ok = 1'b1;
				end
			end
			KIND_INS_UPD: begin
				if (pos >= 0) begin
					value_mirror[pos] = value;
					outcome.ok = 1'b1;
				end else if (mirror_count < CAPACITY) begin
					key_mirror[mirror_count]   = key;
					value_mirror[mirror_count] = value;
					mirror_count++;
					outcome.ok = 1'b1;
				end
			end
			KIND_ERASE: begin
				// The last entry fills the hole.
				if (pos >= 0) begin
					key_mirror[pos]   = key_mirror[mirror_count - 1];
					value_mirror[pos] = value_mirror[mirror_count - 1];
					mirror_count--;
					outcome.ok = 1'b1;
				end
			end
			KIND_LOOKUP: begin
				if (pos >= 0) begin
					outcome.value_out = value_mirror[pos];
					outcome.ok = 1'b1;
				end
			end
			KIND_READ_INDEX: begin
				if (int'(index) < mirror_count) begin
					outcome.key_out   = key_mirror[index];
					outcome.value_out = value_mirror[index];
					outcome.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		outcome.entry_count = COUNT_W'(mirror_count);
		outcome.is_empty    = (mirror_count == 0);
		return outcome;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] key_value_table mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_result();
		table_result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("response beat with no operation outstanding");
			return;
		end
		want = awaited_results.pop_front();
		if (rsp.ok !== want.ok)
			report_mismatch($sformatf("beat %0d ok %b, expected %b",
				beat_number, rsp.ok, want.ok));
		if (rsp.key_out !== want.key_out)
			report_mismatch($sformatf("beat %0d key_out %h, expected %h",
				beat_number, rsp.key_out, want.key_out));
		if (rsp.value_out !== want.value_out)
			report_mismatch($sformatf("beat %0d value_out %h, expected %h",
				beat_number, rsp.value_out, want.value_out));
		if (rsp.entry_count !== want.entry_count)
			report_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
				beat_number, rsp.entry_count, want.entry_count));
		if (rsp.is_empty !== want.is_empty)
			report_mismatch($sformatf("beat %0d is_empty %b, expected %b",
				beat_number, rsp.is_empty, want.is_empty));
		beat_number++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			mirror_count = 0;
			beat_number  = 0;
			fail_count   = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready)
				awaited_results.push_back(apply_operation(req.kind, req.key, req.value,
					req.index));
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ----- sim/key_value_table_tb.sv -----
`timescale 1ns / 100ps
// Testbench top of the key-value table: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on kvt_pkg, the channel interfaces,
// key_value_table and key_value_table_checker.
module key_value_table_tb;
	import kvt_pkg::*;

	// Keys are drawn from a pool a little larger than the table, so that random
	// operations mostly hit stored keys and a run of fresh inserts fills the table.
	localparam int KEY_POOL_SIZE = 320;

	// One operation scans at most every entry, so this many quiet cycles after the
	// last response is enough for any stray beat to show itself.
	localparam int DRAIN_CYCLES = CAPACITY + 16;

	// Generous bound on the whole run: several times the slowest legal run.
	localparam int RUN_LIMIT_NS = 4_000_000;

	// Kind codes that the block does not define; they must fail and change nothing.
	localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

	// Moods of the response receiver.
	typedef enum int {
		RX_STEADY,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic             clk;
	logic             arst_n;
	int               fail_count;
	int               outstanding;
	logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
	int               grow_ptr;
	int               burst_left;
	rx_mode_t         rx_mode;
	int               rx_mode_left;
	int               rx_stall_left;

	kvt_req_if req_ch ();
	kvt_rsp_if rsp_ch ();

	key_value_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// The checker watches both channels and keeps the failure count; this module
	// only makes the stimulus and gives the verdict.
	key_value_table_checker table_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drives one request beat and returns just after the edge that accepts it.
	// The sender works in bursts; before each burst it may sit idle for a random
	// gap, and about a third of the bursts follow on without any gap at all.
	// Valid is only lowered when no new beat is raised in the same time step.
	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value, input logic [INDEX_W-1:0] index);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.kind  <= kind;
		req_ch.key   <= key;
		req_ch.value <= value;
		req_ch.index <= index;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Holds the request channel quiet until every outstanding response has come
	// back. The count from the checker is registered, hence the first wait.
	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// One random operation. Inserts take the next key of the pool, so that a phase
	// heavy in inserts grows the table towards full; everything else takes a pool
	// key at random, which is usually stored. A few lookups use a fully random key
	// that is almost surely absent, and a few beats carry the undefined kinds.
	task automatic random_op(input int insert_weight, input int erase_weight);
		int                 roll;
		logic [KIND_W-1:0]  kind;
		logic [KEY_W-1:0]   key;
		logic [INDEX_W-1:0] index;
		roll  = $urandom_range(0, 99);
		key   = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		index = INDEX_W'($urandom_range(0, 255));
		if (roll < insert_weight) begin
			kind = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_INS_UPD;
			key = key_pool[grow_ptr];
			grow_ptr = (grow_ptr + 1) % KEY_POOL_SIZE;
		end else if (roll < insert_weight + erase_weight) begin
			kind = KIND_ERASE;
		end else begin
			case ($urandom_range(0, 11))
				0, 1: kind = KIND_UPDATE;
				2: kind = KIND_INS_UPD;
				3, 4, 5: kind = KIND_LOOKUP;
				6, 7, 8: kind = KIND_READ_INDEX;
				9: begin
					kind = KIND_LOOKUP;
					key = $urandom();
				end
				10: kind = KIND_RESERVED_LO;
				default: kind = KIND_RESERVED_HI;
			endcase
		end
		send_op(kind, key, $urandom(), index);
	endtask

	// The receiver picks a new mood at random when the current one runs out: steady
	// stretches with no stall at all, rare short stalls when light and longer, more frequent ones when heavy.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_mode       = RX_STEADY;
			rx_mode_left  = 0;
			rx_stall_left = 0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(50, 400);
			end else begin
				rx_mode_left--;
			end
			if (rx_stall_left != 0) begin
				rx_stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_mode == RX_STEADY) begin
				rsp_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < ((rx_mode == RX_LIGHT) ? 15 : 45)) begin
				rx_stall_left = $urandom_range(0, (rx_mode == RX_LIGHT) ? 3 : 11);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= KIND_INSERT;
		req_ch.key   <= '0;
		req_ch.value <= '0;
		req_ch.index <= '0;
		grow_ptr   = 0;
		burst_left = 0;
		for (int i = 0; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom();
		// The extreme keys belong to the pool as well, so random traffic meets them.
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First every kind but the inserting ones on the empty table:
		// reads, searches and erases all miss, and the undefined kinds fail.
		send_op(KIND_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		send_op(KIND_UPDATE, 32'h0000_0000, 32'h1234_5678, 8'd0);
		send_op(KIND_RESERVED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		send_op(KIND_RESERVED_HI, 32'h0000_0000, 32'h0000_0000, 8'd0);

		// Extreme keys and values, a duplicate insert, an update, and
		// insert-or-update both on a present key and as an append.
		send_op(KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
		send_op(KIND_INSERT, 32'h0000_0000, 32'h1234_5678, 8'd0);
		send_op(KIND_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd0);
		send_op(KIND_INS_UPD, 32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
		send_op(KIND_INS_UPD, 32'h8000_0001, 32'h0000_0000, 8'd0);
		send_op(KIND_INSERT, 32'h7FFF_FFFE, 32'h5555_5555, 8'd0);
		send_op(KIND_RESERVED_LO, 32'h0000_0000, 32'h0000_0000, 8'd0);

		// Lookups that hit and miss, reads at the first and last position, one
		// just past the count and one at the top of the index range.
		send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
		send_op(KIND_LOOKUP, 32'h0001_2345, 32'h0000_0000, 8'd0);
		send_op(KIND_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd3);
		send_op(KIND_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd4);
		send_op(KIND_READ_INDEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);

		// Erasing the first entry pulls the last one into its place; then the
		// last entry itself, an absent key, and the rest until the table is empty.
		send_op(KIND_ERASE, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_READ_INDEX, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_ERASE, 32'h8000_0001, 32'h0000_0000, 8'd0);
		send_op(KIND_ERASE, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_op(KIND_ERASE, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
		send_op(KIND_ERASE, 32'h7FFF_FFFE, 32'h0000_0000, 8'd0);

		// The sender waits here for every response before random traffic starts.
		pause_until_drained();

		// Growth: mostly fresh inserts, so the table fills up and the later inserts
		// and appends meet a full table.
		repeat (330) random_op(88, 3);
		pause_until_drained();

		// Mixed traffic on a full or nearly full table, then a phase heavy in
		// erases that shrinks it again.
		repeat (140) random_op(25, 20);
		repeat (180) random_op(5, 70);

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("key_value_table verification clean");
		else
			$display("key_value_table verification failed");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("key_value_table verification failed");
		$finish;
	end

endmodule
